// ===== rtl/scii_pkg.sv =====
package scii_pkg;

  localparam int TableDepth = 64;
  localparam int ValueBits  = 32;
  localparam int IdxBits    = $clog2(TableDepth);
  localparam int CntBits    = $clog2(TableDepth + 1);

  typedef logic [1:0] action_t;
  localparam action_t ActClear  = 2'd0;
  localparam action_t ActInsert = 2'd1;
  localparam action_t ActQuery  = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t StDone    = 3'd0;
  localparam status_t StMatch   = 3'd1;
  localparam status_t StNoMatch = 3'd2;
  localparam status_t StFull    = 3'd3;
  localparam status_t StEmpty   = 3'd4;

  typedef struct packed {
    action_t               action;
    logic [ValueBits-1:0]  curve_x;
    logic [ValueBits-1:0]  curve_y;
    logic [ValueBits-1:0]  data_x;
    logic [ValueBits-1:0]  data_y;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [ValueBits-1:0]  mapped_x;
    logic [ValueBits-1:0]  shift;
  } out_item_t;

  // Request to the divider and its answer.
  typedef struct packed {
    logic                    start;
    logic [2*ValueBits:0]    num;   // |product|, unsigned
    logic [ValueBits:0]      den;   // positive
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [2*ValueBits:0]    quo;
  } div_rsp_t;

endpackage

// ===== rtl/sorted_curve_inverse_interpolator_top.sv =====
// Clear, an undefined action, an insert into a full table and a query on an empty
// table go straight to the output. An insert moves each entry that sorts after the
// new point up one place, then writes the point. A query checks the first and last
// ordinates, scans the segments in order and, when one brackets the ordinate,
// multiplies and runs the divider.
// One item at a time, the next taken in the cycle after the result leaves; reset empties the table.
module sorted_curve_inverse_interpolator_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  scii_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output scii_pkg::out_item_t  out_item_o
);

  // Sequencer with the point memory, plus a restoring divider.
  scii_pkg::div_req_t div_req;
  scii_pkg::div_rsp_t div_rsp;

  scii_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .div_req_o(div_req), .div_rsp_i(div_rsp)
  );

  scii_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

endmodule

// ===== rtl/scii_div.sv =====
module scii_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scii_pkg::div_req_t  req_i,
  output scii_pkg::div_rsp_t  rsp_o
);

  localparam int NW = 2 * scii_pkg::ValueBits + 1;
  localparam int DW = scii_pkg::ValueBits + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DW-1:0], quo_q[NW-1]};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one numerator bit into the remainder, subtract if it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/scii_ctrl.sv =====
module scii_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  scii_pkg::in_item_t    in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output scii_pkg::out_item_t   out_item_o,
  output scii_pkg::div_req_t    div_req_o,
  input  scii_pkg::div_rsp_t    div_rsp_i
);

  localparam int VB = scii_pkg::ValueBits;
  localparam int IB = scii_pkg::IdxBits;
  localparam int CB = scii_pkg::CntBits;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_QRY_RD0, S_QRY_CHK0, S_QRY_LAST,
    S_SCAN_RD, S_SCAN_CMP, S_MUL, S_DIV, S_FIN, S_OUT
  } state_e;

  // Point table: x and y side by side in one memory word.
  logic [2*VB-1:0] mem [scii_pkg::TableDepth];
  logic [2*VB-1:0] rd_q;
  logic [IB-1:0]   rd_addr, wr_addr;
  logic            wr_en;
  logic [2*VB-1:0] wr_data;

  state_e                 state_q;
  logic [CB-1:0]          cnt_q;
  logic [CB-1:0]          pos_q;
  scii_pkg::in_item_t     item_q;
  scii_pkg::out_item_t    res_q;
  logic                   ovalid_q;
  logic signed [VB-1:0]   x0_q, y0_q;
  logic                   neg_q, start_q;
  logic [VB-1:0]          num_q, mag_q;
  logic [2*VB:0]          prod_q;
  logic [VB:0]            den_q;

  logic signed [VB-1:0] rx, ry, cx, cy, dy;
  logic                 less;
  logic signed [VB:0]   run;
  logic [VB:0]          mag, num;
  logic signed [2*VB+1:0] nx;
  scii_pkg::status_t    acc_status;

  assign rx = rd_q[2*VB-1:VB];
  assign ry = rd_q[VB-1:0];
  assign cx = item_q.curve_x;
  assign cy = item_q.curve_y;
  assign dy = item_q.data_y;
  assign less = (cx < rx) || ((cx == rx) && (cy < ry));
  assign run  = {rx[VB-1], rx} - {x0_q[VB-1], x0_q};
  assign mag  = run[VB] ? (VB+1)'(-run) : (VB+1)'(run);
  assign num  = {y0_q[VB-1], y0_q} - {dy[VB-1], dy};
  assign nx   = neg_q ? ((2*VB+2)'(x0_q) - {1'b0, div_rsp_i.quo})
                      : ((2*VB+2)'(x0_q) + {1'b0, div_rsp_i.quo});

  // Status known at acceptance: full table on insert, empty table on query.
  always_comb begin
    acc_status = scii_pkg::StDone;
    if (in_item_i.action == scii_pkg::ActInsert && cnt_q == CB'(scii_pkg::TableDepth))
      acc_status = scii_pkg::StFull;
    if (in_item_i.action == scii_pkg::ActQuery && cnt_q == '0)
      acc_status = scii_pkg::StEmpty;
  end

  always_comb begin
    rd_addr = pos_q[IB-1:0];
    if (state_q == S_QRY_RD0)  rd_addr = '0;
    if (state_q == S_QRY_CHK0) rd_addr = IB'(cnt_q - 1'b1);
    if (state_q == S_INS_RD)   rd_addr = IB'(pos_q - 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  function automatic logic [VB-1:0] sat(input logic signed [2*VB+1:0] v);
    if (v > (2*VB+2)'(signed'({1'b0, {(VB-1){1'b1}}}))) return {1'b0, {(VB-1){1'b1}}};
    if (v < -(2*VB+2)'(signed'({1'b0, {(VB-1){1'b1}}})) - 1) return {1'b1, {(VB-1){1'b0}}};
    return v[VB-1:0];
  endfunction

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_q[IB-1:0];
    wr_data = {cx, cy};
    if (state_q == S_INS_CMP) begin
      wr_en = 1'b1;
      // move the neighbour up one place; at the front rd_q is stale
      if (pos_q != '0 && less) wr_data = rd_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE) || ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_item_o  = res_q;
  assign div_req_o.start = start_q;
  assign div_req_o.num   = prod_q;
  assign div_req_o.den   = den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
      start_q  <= 1'b0;
    end else begin
      start_q <= (state_q == S_MUL);
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            item_q <= in_item_i;
            res_q  <= '{status: acc_status, mapped_x: '0, shift: '0};
            pos_q  <= cnt_q;
            unique case (in_item_i.action)
              scii_pkg::ActClear: begin
                cnt_q <= '0;
                state_q <= S_OUT;
              end
              scii_pkg::ActInsert: begin
                if (cnt_q == CB'(scii_pkg::TableDepth)) state_q <= S_OUT;
                else if (cnt_q == '0) state_q <= S_INS_CMP;
                else state_q <= S_INS_RD;
              end
              scii_pkg::ActQuery: begin
                if (cnt_q == '0) state_q <= S_OUT;
                else state_q <= S_QRY_RD0;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_INS_RD: state_q <= S_INS_CMP;
        S_INS_CMP: begin
          // pos_q == 0 means nothing left below; rd_q is stale then
          if (pos_q != '0 && less) begin
            pos_q <= pos_q - 1'b1;
            state_q <= (pos_q == CB'(1)) ? S_INS_CMP : S_INS_RD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            state_q <= S_OUT;
          end
        end
        S_QRY_RD0: state_q <= S_QRY_CHK0;
        S_QRY_CHK0: begin
          if (dy > ry) begin
            res_q.status <= scii_pkg::StNoMatch;
            state_q <= S_OUT;
          end else begin
            x0_q <= rx;
            y0_q <= ry;
            state_q <= S_QRY_LAST;
          end
        end
        S_QRY_LAST: begin
          if (dy < ry || cnt_q == CB'(1)) begin
            res_q.status <= scii_pkg::StNoMatch;
            state_q <= S_OUT;
          end else begin
            pos_q <= CB'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (dy <= y0_q && dy > ry) begin
            // both magnitudes stay below 2^VB: y0 - dy < y0 - y1, |run| < 2^VB
            neg_q  <= run[VB];
            num_q  <= num[VB-1:0];
            mag_q  <= mag[VB-1:0];
            den_q  <= (VB+1)'({y0_q[VB-1], y0_q} - {ry[VB-1], ry});
            state_q <= S_MUL;
          end else if (pos_q + 1'b1 == cnt_q) begin
            res_q.status <= scii_pkg::StNoMatch;
            state_q <= S_OUT;
          end else begin
            x0_q <= rx;
            y0_q <= ry;
            pos_q <= pos_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_MUL: begin
          prod_q  <= (2*VB+1)'(num_q * mag_q);
          state_q <= S_DIV;
        end
        S_DIV: if (div_rsp_i.done) state_q <= S_FIN;
        S_FIN: begin
          if (nx > 0) begin
            res_q <= '{status: scii_pkg::StMatch, mapped_x: sat(nx),
                       shift: sat(nx - (2*VB+2)'(signed'(item_q.data_x)))};
          end else res_q.status <= scii_pkg::StNoMatch;
          state_q <= S_OUT;
        end
        S_OUT: begin
          ovalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sorted_curve_inverse_interpolator_top_tb.sv =====
module sorted_curve_inverse_interpolator_top_tb;

  localparam int Depth = scii_pkg::TableDepth;
  localparam int ValueBits = scii_pkg::ValueBits;
  localparam int WatchdogLimit = 20000;
  localparam scii_pkg::action_t ActSpare = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  scii_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  scii_pkg::out_item_t out_item_o;

  sorted_curve_inverse_interpolator_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Shadow copy of the curve table, kept by the predictor.
  longint    curve_xs[Depth];
  longint    curve_ys[Depth];
  int        curve_count;
  scii_pkg::out_item_t pending_results[$];

  int  error_count;
  int  items_sent;
  int  results_seen;
  int  matches_seen;
  int  idle_cycles;
  bit  quiet_mode;
  bit  hold_off;
  bit  timed_out;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Saturate to the signed value width.
  function automatic logic [ValueBits-1:0] clamp_value(longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (ValueBits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[ValueBits-1:0];
  endfunction

  // Compute the expected result of one item and advance the shadow table.
  function automatic scii_pkg::out_item_t interpolate_item(scii_pkg::in_item_t it);
    scii_pkg::out_item_t r;
    longint    cx, cy, dx, dy, nx, run;
    logic [127:0] prod, q;
    bit        found;
    int        pos;
    r = '0;
    r.status = scii_pkg::StDone;
    cx = longint'($signed(it.curve_x));
    cy = longint'($signed(it.curve_y));
    dx = longint'($signed(it.data_x));
    dy = longint'($signed(it.data_y));
    found = 1'b0;
    nx = 0;
    case (it.action)
      scii_pkg::ActClear: begin
        curve_count = 0;
      end
      scii_pkg::ActInsert: begin
        if (curve_count >= Depth) begin
          r.status = scii_pkg::StFull;
        end else begin
          pos = curve_count;
          while (pos > 0 && (cx < curve_xs[pos-1] ||
                 (cx == curve_xs[pos-1] && cy < curve_ys[pos-1]))) begin
            curve_xs[pos] = curve_xs[pos-1];
            curve_ys[pos] = curve_ys[pos-1];
            pos--;
          end
          curve_xs[pos] = cx;
          curve_ys[pos] = cy;
          curve_count++;
        end
      end
      scii_pkg::ActQuery: begin
        if (curve_count == 0) begin
          r.status = scii_pkg::StEmpty;
        end else if (dy > curve_ys[0] || dy < curve_ys[curve_count-1]) begin
          r.status = scii_pkg::StNoMatch;
        end else begin
          for (int j = 0; j + 1 < curve_count && !found; j++) begin
            if (!(dy > curve_ys[j] || dy <= curve_ys[j+1])) begin
              run = curve_xs[j+1] - curve_xs[j];
              prod = 128'(curve_ys[j] - dy) * 128'(run < 0 ? -run : run);
              q = prod / 128'(curve_ys[j] - curve_ys[j+1]);
              nx = run < 0 ? curve_xs[j] - longint'(q) : curve_xs[j] + longint'(q);
              found = 1'b1;
            end
          end
          if (found && nx > 0) begin
            r.status   = scii_pkg::StMatch;
            r.mapped_x = clamp_value(nx);
            r.shift    = clamp_value(nx - dx);
          end else begin
            r.status = scii_pkg::StNoMatch;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h, want %h (result %0d)", what, got, want, results_seen);
    error_count++;
  endtask

  // Random gap roughly 6 times in a hundred, unless in a quiet stretch.
  function automatic bit take_gap();
    return !quiet_mode && ($urandom_range(99) < 6);
  endfunction

  // Offer one item at the falling edge and hold it until accepted.
  task automatic send_item(scii_pkg::in_item_t it);
    scii_pkg::out_item_t predicted;
    while (take_gap()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = interpolate_item(it);
    pending_results = {pending_results, predicted};
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [ValueBits-1:0] q16(int whole);
    return ValueBits'(longint'(whole) <<< 16);
  endfunction

  function automatic scii_pkg::in_item_t make_item(scii_pkg::action_t a,
      logic [ValueBits-1:0] cx, logic [ValueBits-1:0] cy,
      logic [ValueBits-1:0] dx, logic [ValueBits-1:0] dy);
    scii_pkg::in_item_t it;
    it.action = a;
    it.curve_x = cx;
    it.curve_y = cy;
    it.data_x = dx;
    it.data_y = dy;
    return it;
  endfunction

  // Random abscissa/ordinate: mostly small, sometimes at the extremes.
  function automatic logic [ValueBits-1:0] pick_value();
    case ($urandom_range(9))
      0: return $urandom();
      1: return {1'b0, {(ValueBits-1){1'b1}}};
      2: return {1'b1, {(ValueBits-1){1'b0}}};
      default: return ValueBits'($signed($urandom_range(4000)) - 1000) <<< 12;
    endcase
  endfunction

  // Check each result against the oldest prediction.
  always @(posedge clk_i) begin
    scii_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("UNEXPECTED result: status %0d", out_item_o.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.status !== want.status)
          report_mismatch("status", 64'(out_item_o.status), 64'(want.status));
        if (out_item_o.mapped_x !== want.mapped_x)
          report_mismatch("mapped_x", 64'(out_item_o.mapped_x), 64'(want.mapped_x));
        if (out_item_o.shift !== want.shift)
          report_mismatch("shift", 64'(out_item_o.shift), 64'(want.shift));
        if (want.status == scii_pkg::StMatch) matches_seen++;
      end
      results_seen++;
    end
  end

  // Drive the output stall at the falling edge; a long hold-off when asked.
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= hold_off || take_gap();
  end

  // Watchdog: count cycles with nothing accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        timed_out = 1'b1;
      end
    end
  end

  // Extremes, every action and each special case but a full table.
  task automatic test_directed();
    send_item(make_item(scii_pkg::ActQuery, '0, '0, q16(1), q16(1)));   // empty table
    send_item(make_item(ActSpare, '1, '1, '1, '1));                    // undefined action
    send_item(make_item(scii_pkg::ActInsert, q16(1), q16(10), '0, '0));
    send_item(make_item(scii_pkg::ActInsert, q16(5), q16(2), '0, '0));
    send_item(make_item(scii_pkg::ActInsert, q16(3), q16(6), '0, '0));
    send_item(make_item(scii_pkg::ActInsert, q16(3), q16(6), '0, '0));   // duplicate
    send_item(make_item(scii_pkg::ActQuery, '0, '0, q16(2), q16(8)));
    send_item(make_item(scii_pkg::ActQuery, '0, '0, q16(2), q16(10)));   // top of range
    send_item(make_item(scii_pkg::ActQuery, '0, '0, q16(2), q16(2)));    // bottom, no segment
    send_item(make_item(scii_pkg::ActQuery, '0, '0, q16(2), q16(11)));   // above
    send_item(make_item(scii_pkg::ActQuery, '0, '0, q16(2), q16(1)));    // below
    send_item(make_item(scii_pkg::ActQuery, '0, '0, {1'b1, {(ValueBits-1){1'b0}}}, q16(5)));
    send_item(make_item(scii_pkg::ActQuery, '0, '0, {1'b0, {(ValueBits-1){1'b1}}}, q16(5)));
    send_item(make_item(scii_pkg::ActClear, '1, '1, '1, '1));
    // Extreme points: a curve across the full range, where the shift saturates.
    send_item(make_item(scii_pkg::ActInsert, {1'b1, {(ValueBits-1){1'b0}}},
                        {1'b0, {(ValueBits-1){1'b1}}}, '0, '0));
    send_item(make_item(scii_pkg::ActInsert, {1'b0, {(ValueBits-1){1'b1}}},
                        {1'b1, {(ValueBits-1){1'b0}}}, '0, '0));
    send_item(make_item(scii_pkg::ActQuery, '0, '0, q16(-5), 32'h8000_0001));
    send_item(make_item(scii_pkg::ActQuery, '0, '0, {1'b1, {(ValueBits-1){1'b0}}},
                        -32'sd100));
    send_item(make_item(scii_pkg::ActQuery, '0, '0, q16(1), q16(100)));
    send_item(make_item(scii_pkg::ActClear, '0, '0, '0, '0));
    wait_drained();
  endtask

  // Fill the table past its depth while the receiver holds off.
  task automatic test_full_table_under_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    for (int k = 0; k < Depth + 4; k++)
      send_item(make_item(scii_pkg::ActInsert, pick_value(), pick_value(), '0, '0));
    for (int k = 0; k < 6; k++)
      send_item(make_item(scii_pkg::ActQuery, '0, '0, pick_value(), pick_value()));
    wait_drained();   // sender pauses until all results are back
  endtask

  // Build small random curves and query them, with a little noise.
  task automatic test_random_curves(int budget);
    int points;
    logic [ValueBits-1:0] lo_y, hi_y;
    lo_y = '0;
    hi_y = '0;
    while (budget > 0) begin
      quiet_mode = ($urandom_range(9) == 0);
      send_item(make_item(scii_pkg::ActClear, $urandom(), $urandom(), $urandom(),
                          $urandom()));
      points = $urandom_range(1, 10);
      for (int k = 0; k < points; k++)
        send_item(make_item(scii_pkg::ActInsert, pick_value(), pick_value(), $urandom(),
                            $urandom()));
      for (int k = 0; k < 8; k++) begin
        // Aim most queries inside the span of the stored ordinates.
        if (curve_count > 0) begin
          lo_y = ValueBits'(curve_ys[curve_count-1]);
          hi_y = ValueBits'(curve_ys[0]);
        end
        if (curve_count > 0 && $urandom_range(3) != 0 && $signed(hi_y) >= $signed(lo_y))
          send_item(make_item(scii_pkg::ActQuery, $urandom(), $urandom(), pick_value(),
            ValueBits'($signed(lo_y) + longint'(($signed(hi_y) - longint'($signed(lo_y)))
              * $urandom_range(1000)) / 1000)));
        else
          send_item(make_item(scii_pkg::action_t'($urandom_range(3)), pick_value(),
                              pick_value(), pick_value(), pick_value()));
      end
      budget -= points + 9;
    end
    quiet_mode = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    hold_off = 1'b0;
    quiet_mode = 1'b0;
    curve_count = 0;
    items_sent = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    fork
      begin
        test_directed();
        test_full_table_under_backpressure();
        test_random_curves(820);
        repeat (200) @(negedge clk_i);
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("Verification failed");
    end else begin
      $display("Run covered %0d items, %0d results, %0d interpolated matches.",
               items_sent, results_seen, matches_seen);
      if (error_count == 0 && pending_results.size() == 0) $display("Verification passed");
      else $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/scii_pkg.sv
rtl/scii_div.sv
rtl/scii_ctrl.sv
rtl/sorted_curve_inverse_interpolator_top.sv
tb/sorted_curve_inverse_interpolator_top_tb.sv
